@@ src/assert_macros.svh @@
// Assertion helpers shared by checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ src/wfc_pkg.sv @@
package wfc_pkg;
  localparam int MaxWordsDef   = 64;
  localparam int MaxWordLenDef = 20;
  localparam int CharW         = 8;
  localparam int LenW          = 5;
  localparam int CountW        = 16;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CharW-1:0] ChSpace  = 8'd32;
  localparam logic [CharW-1:0] ChComma  = 8'd44;
  localparam logic [CharW-1:0] ChPeriod = 8'd46;
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChLowA = 8'd97;
  localparam logic [CharW-1:0] ChLowZ = 8'd122;
  localparam logic [CharW-1:0] CaseOff = 8'd32;

  // Word travelling down the chain of cells.
  typedef struct packed {
    logic [MaxWordLenDef*CharW-1:0] chars;
    logic [LenW-1:0]                len;
  } word_t;

  // Command issued to the head of the chain.
  typedef struct packed {
    logic  lookup;  // search and insert a completed word
    logic  dump;    // shift stored entries out toward the head
    word_t word;
  } chain_cmd_t;

  // Status returned by the chain for one lookup.
  typedef struct packed {
    logic hit;
  } chain_stat_t;

  function automatic logic is_sep(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChComma) || (c == ChPeriod) || (c == ChNewline);
  endfunction

  function automatic logic [CharW-1:0] to_upper(input logic [CharW-1:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) ? (c - CaseOff) : c;
  endfunction
endpackage

@@ src/wfc_cell.sv @@
module wfc_cell import wfc_pkg::*; #(
  parameter int MaxWordLen = MaxWordLenDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // Broadcast lookup word and the hit flag gathered over the whole chain.
  input  logic        lookup,
  input  word_t       word,
  input  logic        hit_any,
  input  logic        prev_valid,
  output logic        match_o,
  output logic        valid_o,
  // Dump: shift entry toward the head.
  input  logic        shift,
  input  word_t       next_word,
  input  logic [CountW-1:0] next_count,
  input  logic        next_valid,
  output word_t       word_o,
  output logic [CountW-1:0] count_o,
  input  logic        clear
);
  word_t             word_r, word_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              valid_r, valid_nxt;
  logic              match;

  always_comb begin
    match = valid_r && (word_r.len == word.len) &&
            (word_r.chars[MaxWordLen*CharW-1:0] == word.chars[MaxWordLen*CharW-1:0]);
    word_nxt  = word_r;
    count_nxt = count_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (shift) begin
      word_nxt  = next_word;
      count_nxt = next_count;
      valid_nxt = next_valid;
    end else if (lookup) begin
      if (match) begin
        if (count_r != CountMax) count_nxt = count_r + 1'b1;
      end else if (!valid_r && prev_valid && !hit_any) begin
        word_nxt  = word;
        count_nxt = {{(CountW-1){1'b0}}, 1'b1};
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    count_r <= count_nxt;
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  assign match_o = match;
  assign valid_o = valid_r;
  assign word_o  = word_r;
  assign count_o = count_r;
endmodule

@@ src/wfc_chain.sv @@
module wfc_chain import wfc_pkg::*; #(
  parameter int MaxWords   = MaxWordsDef,
  parameter int MaxWordLen = MaxWordLenDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  chain_cmd_t  cmd,
  input  logic        clear,
  output chain_stat_t stat,
  output logic        full,
  output logic        head_valid,
  output word_t       head_word,
  output logic [CountW-1:0] head_count,
  output logic        second_valid
);
  logic [MaxWords-1:0] match_c;
  logic [MaxWords-1:0] val_c;
  word_t               w_c [MaxWords];
  logic [CountW-1:0]   n_c [MaxWords];
  logic                hit_any;

  // Every cell compares at once; the hit is a flat reduction over all cells.
  assign hit_any = |match_c;

  for (genvar i = 0; i < MaxWords; i++) begin : g_cell
    logic              pv;
    logic              nv;
    word_t             nw;
    logic [CountW-1:0] nc;
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_prev
      assign pv = val_c[i-1];
    end
    if (i == MaxWords - 1) begin : g_last
      assign nv = 1'b0;
      assign nw = '0;
      assign nc = '0;
    end else begin : g_next
      assign nv = val_c[i+1];
      assign nw = w_c[i+1];
      assign nc = n_c[i+1];
    end
    wfc_cell #(.MaxWordLen(MaxWordLen)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .lookup(cmd.lookup), .word(cmd.word),
      .hit_any(hit_any), .prev_valid(pv),
      .match_o(match_c[i]), .valid_o(val_c[i]),
      .shift(cmd.dump), .next_word(nw), .next_count(nc),
      .next_valid(nv), .word_o(w_c[i]), .count_o(n_c[i]), .clear(clear)
    );
  end

  assign stat.hit     = hit_any;
  assign full         = val_c[MaxWords-1];
  assign head_valid   = val_c[0];
  assign head_word    = w_c[0];
  assign head_count   = n_c[0];
  assign second_valid = val_c[1];
endmodule

@@ src/word_frequency_counter_unit.sv @@
// A character is appended to the pending word when it is taken; a completed word is looked up in the next cycle.
// Throughput: one byte per cycle inside a word; a separator that ends a word holds busy high for the lookup.
// End of text: the transfer, a lookup when a word is pending, then one result per cycle
// for each stored word, then a last dump step that clears the table before busy drops.
// The receiver cannot stall: results are strobed once on out_valid and never repeated.
// Reset (rst_n low, synchronous) empties the table, the pending word and the overflow flag.
module word_frequency_counter_unit import wfc_pkg::*; #(
  parameter int MaxWords   = MaxWordsDef,
  parameter int MaxWordLen = MaxWordLenDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [7:0]   in_char_code,
  input  logic         in_end_of_text,
  output logic         out_valid,
  output logic [63:0]  out_word_chars_low,
  output logic [63:0]  out_word_chars_mid,
  output logic [31:0]  out_word_chars_high,
  output logic [4:0]   out_word_length,
  output logic [15:0]  out_occurrences,
  output logic         out_table_overflowed,
  output logic         out_last_entry
);
  // Controller states: collect characters, look a word up, dump the table.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  word_t  pend_r, pend_nxt;
  logic   eot_r, eot_nxt;
  logic   ovf_r, ovf_nxt;
  chain_cmd_t  cmd;
  chain_stat_t stat;
  logic   full, head_valid, clear;
  logic   second_valid;
  word_t  head_word;
  logic [CountW-1:0] head_count;
  logic [CharW-1:0]  uc;
  logic   accept;
  logic [MaxWordLenDef*CharW-1:0] oc;

  // The pending word is held zero padded so that stored entries compare whole.
  assign accept = start && !busy;
  assign uc     = to_upper(in_char_code);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    eot_nxt   = eot_r;
    ovf_nxt   = ovf_r;
    cmd       = '0;
    cmd.word  = pend_r;
    clear     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          eot_nxt = in_end_of_text;
          if (is_sep(in_char_code)) begin
            if (pend_r.len != '0) state_nxt = S_LOOK;
            else if (in_end_of_text) state_nxt = S_DUMP;
          end else begin
            if (pend_r.len < LenW'(MaxWordLen)) begin
              pend_nxt.chars[pend_r.len*CharW +: CharW] = uc;
              pend_nxt.len = pend_r.len + 1'b1;
            end
            if (in_end_of_text) state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // The whole chain compares in parallel; the first free cell takes a miss.
        cmd.lookup = 1'b1;
        if (!stat.hit && full) ovf_nxt = 1'b1;
        pend_nxt  = '0;
        state_nxt = eot_r ? S_DUMP : S_IDLE;
      end
      S_DUMP: begin
        // Entries shift one cell toward the head each cycle.
        cmd.dump = 1'b1;
        if (!head_valid) begin
          state_nxt = S_IDLE;
          ovf_nxt   = 1'b0;
          clear     = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= '0;
      eot_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      eot_r   <= eot_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  wfc_chain #(.MaxWords(MaxWords), .MaxWordLen(MaxWordLen)) u_chain (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .clear(clear), .stat(stat),
    .full(full), .head_valid(head_valid), .head_word(head_word),
    .head_count(head_count), .second_valid(second_valid)
  );

  // The head cell is shown while dumping; the next cell tells if it is the last.
  assign oc = head_word.chars;
  assign out_valid            = (state_r == S_DUMP) && head_valid;
  assign out_word_chars_low   = oc[63:0];
  assign out_word_chars_mid   = oc[127:64];
  assign out_word_chars_high  = oc[159:128];
  assign out_word_length      = head_word.len;
  assign out_occurrences      = head_count;
  assign out_table_overflowed = ovf_r;
  assign out_last_entry       = head_valid && !second_valid;
endmodule

@@ src/wfc_checker.sv @@
`include "assert_macros.svh"
module wfc_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last_entry,
  input logic [4:0] out_word_length,
  input logic [15:0] out_occurrences
);
  `ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, busy)
  `ASSERT_IMPL(a_len_nz, clk, rst_n, out_valid, out_word_length != 5'd0)
  `ASSERT_IMPL(a_cnt_nz, clk, rst_n, out_valid, out_occurrences != 16'd0)
  `ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_last_entry, !out_valid)
endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_last_entry(out_last_entry), .out_word_length(out_word_length),
  .out_occurrences(out_occurrences)
);
